// File: hw/rtl/first_fit_page_allocator_core_macros.svh
// Assertion macros for the page allocator checker.
// Expect clk and rst_n in the scope of use.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define FFPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffpa checker: property violated");

// next-cycle implication
`define FFPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffpa checker: property violated");

`endif

// File: hw/rtl/ffpa_pkg.sv
// Shared types and constants of the first-fit page allocator.
// No dependencies.
package ffpa_pkg;

    localparam int ADDR_W     = 64;
    localparam int PAGE_SHIFT = 12;
    localparam int PPN_W      = ADDR_W - PAGE_SHIFT;
    localparam int KIND_W     = 32;
    localparam int INFO_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int PIU_W      = 7;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ADDR_W-1:0] PAGE_BYTES = 64'h0000_0000_0000_1000;
    localparam logic [ADDR_W-1:0] PAGE_MASK  = 64'hFFFF_FFFF_FFFF_F000;
    localparam logic [ADDR_W-1:0] LOW_LIMIT  = 64'h0000_0000_0010_0000;
    localparam logic [KIND_W-1:0] KIND_USABLE = 32'd1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOPAGE  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_KRN_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KRN_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STK_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STK_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INFO_SIZE = 3'd5;

    typedef struct packed {
        logic [ADDR_W-1:0] krn_base;
        logic [ADDR_W-1:0] krn_limit;
        logic [ADDR_W-1:0] stk_base;
        logic [ADDR_W-1:0] stk_limit;
        logic [INFO_W-1:0] info_base;
        logic [INFO_W:0]   info_end;
    } cfg_t;

    typedef enum logic [1:0] {
        CHK_SCAN = 2'd0,
        CHK_MOVE = 2'd1,
        CHK_SKIP = 2'd2
    } chk_act_t;

    typedef struct packed {
        chk_act_t          action;
        logic [ADDR_W-1:0] next_page;
    } chk_t;

endpackage

// File: hw/rtl/ffpa_if.sv
// Request and response channel interfaces of the page allocator.
// Depends on ffpa_pkg.
interface ffpa_req_if import ffpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] range_base;
    logic [ADDR_W-1:0] range_length;
    logic [KIND_W-1:0] range_kind;

    modport source (output valid, opcode, range_base, range_length, range_kind,
                    input ready);
    modport sink   (input valid, opcode, range_base, range_length, range_kind,
                    output ready);
    modport mon    (input valid, ready, opcode, range_base, range_length, range_kind);
endinterface

interface ffpa_rsp_if import ffpa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_address;
    logic [PIU_W-1:0]    pages_in_use;

    modport source (output valid, status, page_address, pages_in_use, input ready);
    modport sink   (input valid, status, page_address, pages_in_use, output ready);
    modport mon    (input valid, ready, status, page_address, pages_in_use);
endinterface

// File: hw/rtl/first_fit_page_allocator_core.sv
// First-fit physical page allocator, top level.
// Depends on ffpa_pkg, ffpa_if, ffpa_ram, ffpa_cfg, ffpa_page_check.
//
// Channels: req carries load and allocate requests, rsp returns exactly one
// result per request. cfg_write/cfg_index/cfg_data set the protected regions
// and the user must write them only while the block is idle; it does not enforce this.
// One request is in work at a time; req.ready is high only when idle.
// Load: the accepting edge moves the block to S_RESP; once the output register
// takes the result, it returns to S_IDLE and can take the next request.
// Allocate: for each range visited, S_RREAD reads the table entry, S_RLOAD
// rounds the base up to a page and S_CHECK handles each candidate step (first
// page, low-memory or region jump, next page after a history hit, leaving the
// range); each candidate that passes is tested against the history in S_HSCAN,
// which reads the stored entries in turn until a hit (none when empty); at the end of the
// table with no page found, S_RREAD returns ST_NOPAGE.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and works on the next request and holds its result
// until the register frees.
// Reset clears range and page counts and the region registers; no memory
// clearing pass is needed, the block is ready as soon as reset is released.
module first_fit_page_allocator_core import ffpa_pkg::*; #(
    parameter int HISTORY_DEPTH = 64,
    parameter int RANGE_SLOTS   = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ffpa_req_if.sink             req,
    ffpa_rsp_if.source           rsp,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int RC_W = $clog2(RANGE_SLOTS + 1);
    localparam int RA_W = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
    localparam int HC_W = $clog2(HISTORY_DEPTH + 1);
    localparam int HA_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RREAD = 6'b000010,
        S_RLOAD = 6'b000100,
        S_CHECK = 6'b001000,
        S_HSCAN = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [RC_W-1:0]     rcnt_reg, rcnt_next;
    logic [HC_W-1:0]     hcnt_reg, hcnt_next;
    logic [RC_W-1:0]     r_reg, r_next;
    logic [HC_W-1:0]     idx_reg, idx_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   p_reg, p_next;
    logic [ADDR_W-1:0]   top_reg, top_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_page_reg, res_page_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_page_reg;
    logic [PIU_W-1:0]    out_piu_reg;

    logic                rng_we, rng_re;
    logic [2*ADDR_W-1:0] rng_rdata;
    logic [ADDR_W-1:0]   rng_base, rng_len;
    logic                hist_we, hist_re;
    logic [PPN_W-1:0]    hist_rdata;
    logic                hist_match;
    logic                hist_issue;
    logic [ADDR_W:0]     load_sum;
    logic                out_load;

    cfg_t cfg;
    chk_t chk;

    ffpa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ffpa_page_check u_check (
        .page (p_reg),
        .top  (top_reg),
        .cfg  (cfg),
        .chk  (chk)
    );

    ffpa_ram #(
        .WIDTH (2 * ADDR_W),
        .DEPTH (RANGE_SLOTS)
    ) u_range_ram (
        .clk   (clk),
        .we    (rng_we),
        .waddr (rcnt_reg[RA_W-1:0]),
        .wdata ({req.range_base, req.range_length}),
        .re    (rng_re),
        .raddr (r_reg[RA_W-1:0]),
        .rdata (rng_rdata)
    );

    ffpa_ram #(
        .WIDTH (PPN_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hcnt_reg[HA_W-1:0]),
        .wdata (p_reg[ADDR_W-1:PAGE_SHIFT]),
        .re    (hist_re),
        .raddr (idx_reg[HA_W-1:0]),
        .rdata (hist_rdata)
    );

    assign rng_base   = rng_rdata[2*ADDR_W-1:ADDR_W];
    assign rng_len    = rng_rdata[ADDR_W-1:0];
    assign hist_match = hist_rdata == p_reg[ADDR_W-1:PAGE_SHIFT];
    assign hist_issue = idx_reg < hcnt_reg;
    assign load_sum   = {1'b0, req.range_base} + {1'b0, req.range_length};
    assign out_load   = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    assign req.ready        = state_reg == S_IDLE;
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.page_address = out_page_reg;
    assign rsp.pages_in_use = out_piu_reg;

    always_comb
    begin
        state_next      = state_reg;
        rcnt_next       = rcnt_reg;
        hcnt_next       = hcnt_reg;
        r_next          = r_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        p_next          = p_reg;
        top_next        = top_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        rng_we          = 1'b0;
        rng_re          = 1'b0;
        hist_we         = 1'b0;
        hist_re         = 1'b0;
        out_valid_next  = out_load | (out_valid_reg & ~rsp.ready);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_page_next = '0;
                    state_next    = S_RESP;
                    if (req.opcode == OP_LOAD)
                    begin
                        if (req.range_kind != KIND_USABLE || load_sum[ADDR_W])
                        begin
                            res_status_next = ST_IGNORED;
                        end
                        else if (rcnt_reg >= RC_W'(RANGE_SLOTS))
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            rng_we          = 1'b1;
                            rcnt_next       = rcnt_reg + RC_W'(1);
                            res_status_next = ST_STORED;
                        end
                    end
                    else if (hcnt_reg >= HC_W'(HISTORY_DEPTH))
                    begin
                        res_status_next = ST_NOPAGE;
                    end
                    else
                    begin
                        r_next     = '0;
                        state_next = S_RREAD;
                    end
                end
            end
            S_RREAD:
            begin
                if (r_reg >= rcnt_reg)
                begin
                    res_status_next = ST_NOPAGE;
                    state_next      = S_RESP;
                end
                else
                begin
                    rng_re     = 1'b1;
                    state_next = S_RLOAD;
                end
            end
            S_RLOAD:
            begin
                p_next     = (rng_base + PAGE_BYTES - 64'd1) & PAGE_MASK;
                top_next   = (rng_base + rng_len) & PAGE_MASK;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                case (chk.action)
                    CHK_SKIP:
                    begin
                        r_next     = r_reg + RC_W'(1);
                        state_next = S_RREAD;
                    end
                    CHK_MOVE:
                    begin
                        p_next = chk.next_page;
                    end
                    default:
                    begin
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_HSCAN;
                    end
                endcase
            end
            S_HSCAN:
            begin
                // read one history entry per cycle, compare it in the following cycle
                hist_re   = hist_issue;
                pend_next = hist_issue;
                if (hist_issue)
                begin
                    idx_next = idx_reg + HC_W'(1);
                end
                if (pend_reg && hist_match)
                begin
                    p_next     = p_reg + PAGE_BYTES;
                    state_next = S_CHECK;
                end
                else if (!pend_reg && !hist_issue)
                begin
                    hist_we         = 1'b1;
                    hcnt_next       = hcnt_reg + HC_W'(1);
                    res_status_next = ST_ALLOC;
                    res_page_next   = p_reg;
                    state_next      = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rcnt_reg      <= '0;
            hcnt_reg      <= '0;
            r_reg         <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rcnt_reg      <= rcnt_next;
            hcnt_reg      <= hcnt_next;
            r_reg         <= r_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg          <= p_next;
        top_reg        <= top_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_page_reg   <= res_page_reg;
            out_piu_reg    <= PIU_W'(hcnt_reg);
        end
    end

endmodule

// File: hw/rtl/ffpa_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module ffpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/ffpa_cfg.sv
// Protected-region configuration registers of the page allocator.
// Depends on ffpa_pkg.
module ffpa_cfg import ffpa_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    logic [ADDR_W-1:0] krn_base_reg;
    logic [ADDR_W-1:0] krn_limit_reg;
    logic [ADDR_W-1:0] stk_base_reg;
    logic [ADDR_W-1:0] stk_limit_reg;
    logic [INFO_W-1:0] info_base_reg;
    logic [INFO_W-1:0] info_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krn_base_reg  <= '0;
            krn_limit_reg <= '0;
            stk_base_reg  <= '0;
            stk_limit_reg <= '0;
            info_base_reg <= '0;
            info_size_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KRN_BASE:  krn_base_reg  <= cfg_data;
                REG_KRN_LIMIT: krn_limit_reg <= cfg_data;
                REG_STK_BASE:  stk_base_reg  <= cfg_data;
                REG_STK_LIMIT: stk_limit_reg <= cfg_data;
                REG_INFO_BASE: info_base_reg <= cfg_data[INFO_W-1:0];
                REG_INFO_SIZE: info_size_reg <= cfg_data[INFO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.krn_base  = krn_base_reg;
        cfg.krn_limit = krn_limit_reg;
        cfg.stk_base  = stk_base_reg;
        cfg.stk_limit = stk_limit_reg;
        cfg.info_base = info_base_reg;
        // info region end never wraps: one extra bit
        cfg.info_end  = {1'b0, info_base_reg} + {1'b0, info_size_reg};
    end

endmodule

// File: hw/rtl/ffpa_page_check.sv
// One step of the candidate page test: range end, low memory and the
// three protected regions. Depends on ffpa_pkg.
module ffpa_page_check import ffpa_pkg::*; (
    input  logic [ADDR_W-1:0] page,
    input  logic [ADDR_W-1:0] top,
    input  cfg_t              cfg,
    output chk_t              chk
);

    function automatic logic [ADDR_W-1:0] ceil_page(input logic [ADDR_W-1:0] x);
        logic [PPN_W-1:0] ppn;
        ppn = x[ADDR_W-1:PAGE_SHIFT] + PPN_W'(|x[PAGE_SHIFT-1:0]);
        return {ppn, {PAGE_SHIFT{1'b0}}};
    endfunction

    function automatic logic ceil_ovf(input logic [ADDR_W-1:0] x);
        return (&x[ADDR_W-1:PAGE_SHIFT]) && (|x[PAGE_SHIFT-1:0]);
    endfunction

    logic [ADDR_W-1:0] page_end;
    logic [ADDR_W-1:0] info_lo;
    logic [ADDR_W-1:0] info_hi;

    assign page_end = page + PAGE_BYTES;
    assign info_lo  = {{(ADDR_W-INFO_W){1'b0}}, cfg.info_base};
    assign info_hi  = {{(ADDR_W-INFO_W-1){1'b0}}, cfg.info_end};

    always_comb
    begin
        chk.action    = CHK_SCAN;
        chk.next_page = page;
        // zero page, past range top, or last page of the address space
        if (page == '0 || page >= top || (&page[ADDR_W-1:PAGE_SHIFT]))
        begin
            chk.action = CHK_SKIP;
        end
        else if (page < LOW_LIMIT)
        begin
            chk.action    = CHK_MOVE;
            chk.next_page = LOW_LIMIT;
        end
        else if (page < cfg.krn_limit && cfg.krn_base < page_end)
        begin
            chk.action    = ceil_ovf(cfg.krn_limit) ? CHK_SKIP : CHK_MOVE;
            chk.next_page = ceil_page(cfg.krn_limit);
        end
        else if (page < cfg.stk_limit && cfg.stk_base < page_end)
        begin
            chk.action    = ceil_ovf(cfg.stk_limit) ? CHK_SKIP : CHK_MOVE;
            chk.next_page = ceil_page(cfg.stk_limit);
        end
        else if (page < info_hi && info_lo < page_end)
        begin
            chk.action    = CHK_MOVE;
            chk.next_page = ceil_page(info_hi);
        end
    end

endmodule

// File: hw/rtl/ffpa_checker.sv
// Port-level checks of the page allocator, bound to the top level.
// Depends on ffpa_pkg and the assertion macro header.
`include "first_fit_page_allocator_core_macros.svh"

module ffpa_checker import ffpa_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [ADDR_W-1:0]   rsp_page,
    input logic [PIU_W-1:0]    rsp_piu
);

    logic                               rsp_stall;
    logic                               rsp_alloc;
    logic                               rsp_other;
    logic [STATUS_W+ADDR_W+PIU_W-1:0]   rsp_word;

    assign rsp_stall = rsp_valid && !rsp_ready;
    assign rsp_alloc = rsp_valid && rsp_status == ST_ALLOC;
    assign rsp_other = rsp_valid && rsp_status != ST_ALLOC;
    assign rsp_word  = {rsp_status, rsp_page, rsp_piu};

    `FFPA_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word))
    `FFPA_ASSERT_SAME(a_page_zero, rsp_other, rsp_page == '0)
    `FFPA_ASSERT_SAME(a_page_legal, rsp_alloc, rsp_page[PAGE_SHIFT-1:0] == '0)
    `FFPA_ASSERT_SAME(a_page_high, rsp_alloc, rsp_page >= LOW_LIMIT)
    `FFPA_ASSERT_NEXT(a_one_request, req_valid && req_ready, !req_ready)

endmodule

bind first_fit_page_allocator_core ffpa_checker u_ffpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_page   (rsp.page_address),
    .rsp_piu    (rsp.pages_in_use)
);
